[rtl/tlca_pkg.sv]
// Package for the binary-lifting LCA block: widths, codes, and the command
// and result structs shared by the sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package tlca_pkg;

  localparam int NODE_W  = 10;
  localparam int NODES   = 1 << NODE_W;
  localparam int LEVEL_W = 10;
  localparam int DIST_W  = 11;
  localparam int ENTRY_W = NODE_W + 1;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [DIST_W-1:0]  NO_PATH   = '1;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              func;
    logic              is_root;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] other_node;
  } tlca_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] common_ancestor;
    logic [DIST_W-1:0] distance;
  } tlca_res_t;

endpackage

[rtl/tlca_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tlca_ctrl.sv]
// Sequencer of the LCA block: fills ancestor rows on load and runs the two
// lifting passes on query, one table read per step.
// Depends on tlca_pkg; drives the jump-table and level RAMs of the top level.
`timescale 1ns / 1ps

module tlca_ctrl
  import tlca_pkg::*;
#(
  parameter int LEVELS = 10,
  parameter int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  tlca_cmd_t                  cmd,
  output logic                       jt_we,
  output logic [NODE_W+LW-1:0]       jt_waddr,
  output logic [ENTRY_W-1:0]         jt_wdata,
  output logic [NODE_W+LW-1:0]       jt_raddr,
  input  logic [ENTRY_W-1:0]         jt_rdata,
  output logic                       lv_we,
  output logic [NODE_W-1:0]          lv_waddr,
  output logic [LEVEL_W-1:0]         lv_wdata,
  output logic [NODE_W-1:0]          lv_raddr,
  input  logic [LEVEL_W-1:0]         lv_rdata,
  output tlca_res_t                  res,
  input  logic                       res_ready
);

  localparam int KW = $clog2(LEVELS + 1);
  localparam logic [KW-1:0] K_TOP  = KW'(LEVELS - 1);
  localparam logic [KW-1:0] K_LAST = KW'(LEVELS);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_L_LVL  = 17'h00002,
    S_L_ROOT = 17'h00004,
    S_ROW    = 17'h00008,
    S_ROW_WR = 17'h00010,
    S_Q_LA   = 17'h00020,
    S_Q_LB   = 17'h00040,
    S_P1_RD  = 17'h00080,
    S_P1_E   = 17'h00100,
    S_P1_L   = 17'h00200,
    S_MEET   = 17'h00400,
    S_P2_RA  = 17'h00800,
    S_P2_RB  = 17'h01000,
    S_P2_CMP = 17'h02000,
    S_FIN_RD = 17'h04000,
    S_FIN    = 17'h08000,
    S_DIST   = 17'h10000
  } state_t;

  // One extra state would only hold the result; it is shown in S_IDLE while done_r is set.
  localparam state_t S_DONE_ALIAS = S_IDLE;

  state_t              state_r, state_nxt;
  logic                done_r, done_nxt;
  logic [NODE_W-1:0]   u_r, u_nxt;
  logic [NODE_W-1:0]   v_r, v_nxt;
  logic [NODE_W-1:0]   a_r, a_nxt;
  logic [NODE_W-1:0]   b_r, b_nxt;
  logic [NODE_W-1:0]   e_r, e_nxt;
  logic [LEVEL_W-1:0]  la_r, la_nxt;
  logic [LEVEL_W-1:0]  lb_r, lb_nxt;
  logic [LEVEL_W-1:0]  lvb_r, lvb_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [ENTRY_W-1:0]  mid_r, mid_nxt;
  logic [ENTRY_W-1:0]  ea_r, ea_nxt;
  logic [NODE_W-1:0]   lca_r, lca_nxt;
  logic                found_r, found_nxt;
  logic [NODE_W-1:0]   rca_r, rca_nxt;
  logic [DIST_W-1:0]   rdist_r, rdist_nxt;

  logic [KW-1:0]       km1;
  logic [DIST_W-1:0]   da, db;
  logic                accept;

  assign km1    = k_r - 1'b1;
  assign accept = cmd_valid && cmd_ready;

  // Level differences are floored at zero before they are summed.
  assign da = (la_r > lv_rdata) ? {1'b0, la_r - lv_rdata} : '0;
  assign db = (lb_r > lv_rdata) ? {1'b0, lb_r - lv_rdata} : '0;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    la_nxt    = la_r;
    lb_nxt    = lb_r;
    lvb_nxt   = lvb_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    ea_nxt    = ea_r;
    lca_nxt   = lca_r;
    found_nxt = found_r;
    rca_nxt   = rca_r;
    rdist_nxt = rdist_r;
    jt_we     = 1'b0;
    jt_waddr  = {u_r, k_r[LW-1:0]};
    jt_wdata  = '0;
    jt_raddr  = {a_r, k_r[LW-1:0]};
    lv_we     = 1'b0;
    lv_waddr  = u_r;
    lv_wdata  = '0;
    lv_raddr  = lca_r;

    case (state_r)
      S_IDLE: begin
        if (done_r) begin
          if (res_ready) begin
            done_nxt = 1'b0;
          end
        end else if (accept) begin
          u_nxt = cmd.node;
          v_nxt = cmd.other_node;
          if (cmd.func == FUNC_QUERY) begin
            lv_raddr  = cmd.node;
            state_nxt = S_Q_LA;
          end else if (cmd.is_root) begin
            mid_nxt   = '0;
            k_nxt     = KW'(1);
            state_nxt = S_L_ROOT;
          end else begin
            lv_raddr  = cmd.other_node;
            state_nxt = S_L_LVL;
          end
        end
      end
      S_L_LVL: begin
        lv_we     = 1'b1;
        lv_wdata  = (lv_rdata == LEVEL_MAX) ? LEVEL_MAX : lv_rdata + 1'b1;
        mid_nxt   = {1'b1, v_r};
        k_nxt     = KW'(1);
        state_nxt = S_ROW;
      end
      S_L_ROOT: begin
        lv_we     = 1'b1;
        lv_wdata  = '0;
        state_nxt = S_ROW;
      end
      // Entry k-1 of the row is written in the same cycle as the source of entry k
      // is read, so a row that refers to the node itself still sees the old
      // contents of that entry.
      S_ROW: begin
        jt_we    = 1'b1;
        jt_waddr = {u_r, km1[LW-1:0]};
        jt_wdata = mid_r;
        if (k_r == K_LAST) begin
          state_nxt = S_IDLE;
        end else if (mid_r[ENTRY_W-1]) begin
          jt_raddr  = {mid_r[NODE_W-1:0], km1[LW-1:0]};
          state_nxt = S_ROW_WR;
        end else begin
          mid_nxt = '0;
          k_nxt   = k_r + 1'b1;
        end
      end
      S_ROW_WR: begin
        mid_nxt   = jt_rdata;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_ROW;
      end
      S_Q_LA: begin
        la_nxt    = lv_rdata;
        lv_raddr  = v_r;
        state_nxt = S_Q_LB;
      end
      S_Q_LB: begin
        lb_nxt = lv_rdata;
        if (lv_rdata > la_r) begin
          a_nxt   = v_r;
          b_nxt   = u_r;
          lvb_nxt = la_r;
        end else begin
          a_nxt   = u_r;
          b_nxt   = v_r;
          lvb_nxt = lv_rdata;
        end
        k_nxt     = K_TOP;
        state_nxt = S_P1_RD;
      end
      S_P1_RD: begin
        state_nxt = S_P1_E;
      end
      S_P1_E: begin
        if (jt_rdata[ENTRY_W-1]) begin
          e_nxt     = jt_rdata[NODE_W-1:0];
          lv_raddr  = jt_rdata[NODE_W-1:0];
          state_nxt = S_P1_L;
        end else if (k_r == '0) begin
          state_nxt = S_MEET;
        end else begin
          k_nxt     = km1;
          state_nxt = S_P1_RD;
        end
      end
      S_P1_L: begin
        if (lv_rdata >= lvb_r) begin
          a_nxt = e_r;
        end
        if (k_r == '0) begin
          state_nxt = S_MEET;
        end else begin
          k_nxt     = km1;
          state_nxt = S_P1_RD;
        end
      end
      S_MEET: begin
        if (a_r == b_r) begin
          lca_nxt   = a_r;
          found_nxt = 1'b1;
          lv_raddr  = a_r;
          state_nxt = S_DIST;
        end else begin
          k_nxt     = K_TOP;
          state_nxt = S_P2_RA;
        end
      end
      S_P2_RA: begin
        state_nxt = S_P2_RB;
      end
      S_P2_RB: begin
        ea_nxt    = jt_rdata;
        jt_raddr  = {b_r, k_r[LW-1:0]};
        state_nxt = S_P2_CMP;
      end
      S_P2_CMP: begin
        if (ea_r != jt_rdata && ea_r[ENTRY_W-1] && jt_rdata[ENTRY_W-1]) begin
          a_nxt = ea_r[NODE_W-1:0];
          b_nxt = jt_rdata[NODE_W-1:0];
        end
        if (k_r == '0) begin
          state_nxt = S_FIN_RD;
        end else begin
          k_nxt     = km1;
          state_nxt = S_P2_RA;
        end
      end
      S_FIN_RD: begin
        jt_raddr  = {a_r, {LW{1'b0}}};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        lca_nxt   = jt_rdata[NODE_W-1:0];
        found_nxt = jt_rdata[ENTRY_W-1];
        lv_raddr  = jt_rdata[NODE_W-1:0];
        state_nxt = S_DIST;
      end
      S_DIST: begin
        if (found_r) begin
          rca_nxt   = lca_r;
          rdist_nxt = da + db;
        end else begin
          rca_nxt   = '0;
          rdist_nxt = NO_PATH;
        end
        done_nxt  = 1'b1;
        state_nxt = S_DONE_ALIAS;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cmd_ready           = (state_r == S_IDLE) && !done_r;
  assign res.valid           = done_r;
  assign res.common_ancestor = rca_r;
  assign res.distance        = rdist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    la_r    <= la_nxt;
    lb_r    <= lb_nxt;
    lvb_r   <= lvb_nxt;
    k_r     <= k_nxt;
    mid_r   <= mid_nxt;
    ea_r    <= ea_nxt;
    lca_r   <= lca_nxt;
    found_r <= found_nxt;
    rca_r   <= rca_nxt;
    rdist_r <= rdist_nxt;
  end

`ifndef SYNTH
  a_row_write_in_load : assert property (@(posedge clk) disable iff (!rst_n)
    jt_we |-> (state_r == S_ROW))
    else $error("jump table written outside a load");

  a_level_write_in_load : assert property (@(posedge clk) disable iff (!rst_n)
    lv_we |-> (state_r == S_L_LVL || state_r == S_L_ROOT))
    else $error("level table written outside a load");

  a_no_path_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.distance == NO_PATH) |-> (res.common_ancestor == '0))
    else $error("unreachable pair reported with a nonzero ancestor");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !cmd_ready)
    else $error("new transaction taken while the previous one runs");
`endif

endmodule

[rtl/tree_lca_binary_lifting.sv]
// Lowest common ancestor and path distance on a rooted tree by binary lifting.
// A load transaction (func = 0) enters one node with its parent, or as a root,
// and fills that node's row of 2^k ancestors from rows loaded before it; parents
// must be loaded before their children. A query transaction (func = 1) returns
// the lowest common ancestor of two loaded nodes and the number of edges between
// them; nodes in different trees give ancestor 0 and distance 2047. Loads give
// no result. One transaction is worked on at a time; a query's running time is
// set by the single read port of the jump-table RAM, which the lifting passes
// read once per step, and by the level RAM read that each step of the first
// pass needs when its ancestor exists. Both tables start undefined after reset;
// no clearing pass is run, and querying a node that was never loaded gives an
// undefined answer.
// Depends on tlca_pkg, tlca_ram and tlca_ctrl.
`timescale 1ns / 1ps

module tree_lca_binary_lifting
  import tlca_pkg::*;
#(
  parameter int LEVELS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] node, [19:10] other_node, [23:20] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] func, [1] is_root
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [9:0] common_ancestor, [20:10] distance, [23:21] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Jump-table rows are addressed as {node, level}, so each row spans a
  // power-of-two slot of at least LEVELS entries.
  localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JT_DEPTH = NODES * (1 << LW);

  tlca_cmd_t                cmd;
  tlca_res_t                res;
  logic                     res_ready;

  logic                     jt_we;
  logic [NODE_W+LW-1:0]     jt_waddr;
  logic [ENTRY_W-1:0]       jt_wdata;
  logic [NODE_W+LW-1:0]     jt_raddr;
  logic [ENTRY_W-1:0]       jt_rdata;
  logic                     lv_we;
  logic [NODE_W-1:0]        lv_waddr;
  logic [LEVEL_W-1:0]       lv_wdata;
  logic [NODE_W-1:0]        lv_raddr;
  logic [LEVEL_W-1:0]       lv_rdata;

  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  assign cmd.func       = in_tuser[0];
  assign cmd.is_root    = in_tuser[1];
  assign cmd.node       = in_tdata[NODE_W-1:0];
  assign cmd.other_node = in_tdata[2*NODE_W-1:NODE_W];

  // Each jump-table entry holds an ancestor-exists flag above the node id.
  tlca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (JT_DEPTH)
  ) u_jump_table (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr),
    .rdata (jt_rdata)
  );

  tlca_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (NODES)
  ) u_node_level (
    .clk   (clk),
    .we    (lv_we),
    .waddr (lv_waddr),
    .wdata (lv_wdata),
    .raddr (lv_raddr),
    .rdata (lv_rdata)
  );

  tlca_ctrl #(
    .LEVELS (LEVELS),
    .LW     (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .jt_we     (jt_we),
    .jt_waddr  (jt_waddr),
    .jt_wdata  (jt_wdata),
    .jt_raddr  (jt_raddr),
    .jt_rdata  (jt_rdata),
    .lv_we     (lv_we),
    .lv_waddr  (lv_waddr),
    .lv_wdata  (lv_wdata),
    .lv_raddr  (lv_raddr),
    .lv_rdata  (lv_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: the sequencer hands over a result whenever this stage is
  // empty or being emptied in the same cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{(OUT_TDATA_W - NODE_W - DIST_W){1'b0}},
                       res.distance, res.common_ancestor};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the binary-lifting LCA block: it streams load and
// query transactions and checks each result against an in-house tree predictor.
// Depends on tlca_pkg and tree_lca_binary_lifting.
`timescale 1ns / 1ps

module tb_top;
  import tlca_pkg::*;

  localparam int LEVELS = 10;
  // Idle time after the last answer, before the run ends.
  localparam int DRAIN_CYCLES = 8 * LEVELS + 16;
  localparam int RANDOM_ITEMS = 450;
  // Length of the chain built in the last part of the run.
  localparam int CHAIN_LEN = 300;
  // Far beyond the slowest legal run; the clock period is 12 ns.
  localparam longint TIMEOUT_NS = 64'd12_000_000;

  // One expected answer, together with the query that produced it so that
  // a mismatch report can say which pair of nodes went wrong.
  typedef struct {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    tlca_res_t         res;
  } lca_expect_t;

  // The scoreboard keeps its own copy of the ancestor rows and node depths.
  // Every accepted load updates that copy; every query queues the answer
  // it must produce, and results are matched in order.
  class lca_scoreboard;
    logic [ENTRY_W-1:0] anc_rows [NODES][LEVELS];
    logic [LEVEL_W-1:0] depth [NODES];
    lca_expect_t        answers_q[$];
    int                 n_errors;

    function new();
      n_errors = 0;
    endfunction

    function int pending();
      return answers_q.size();
    endfunction

    // Edges from a node up to an ancestor's depth, never negative.
    function logic [DIST_W-1:0] edges_up(logic [LEVEL_W-1:0] lvl,
                                         logic [LEVEL_W-1:0] anc_lvl);
      return (lvl > anc_lvl) ? DIST_W'(lvl - anc_lvl) : '0;
    endfunction

    function void note_input(tlca_cmd_t c);
      logic [ENTRY_W-1:0] row [LEVELS];
      logic [ENTRY_W-1:0] ea, eb;
      logic [LEVEL_W:0]   lvl_next;
      logic [NODE_W-1:0]  a, b, t, lca;
      bit                 found;
      lca_expect_t        x;

      if (c.func == FUNC_LOAD) begin
        if (c.is_root) begin
          for (int k = 0; k < LEVELS; k++) row[k] = '0;
          depth[c.node] = '0;
        end else begin
          lvl_next = {1'b0, depth[c.other_node]} + 1'b1;
          if (lvl_next > LEVEL_MAX) lvl_next = LEVEL_MAX;
          // The whole row is built from the old contents before it is
          // written back, which matters when a node becomes its own ancestor.
          row[0] = {1'b1, c.other_node};
          for (int k = 1; k < LEVELS; k++) begin
            if (row[k-1][NODE_W]) row[k] = anc_rows[row[k-1][NODE_W-1:0]][k-1];
            else row[k] = '0;
          end
          depth[c.node] = lvl_next[LEVEL_W-1:0];
        end
        for (int k = 0; k < LEVELS; k++) anc_rows[c.node][k] = row[k];
        return;
      end

      a = c.node;
      b = c.other_node;
      found = 1'b1;
      if (depth[b] > depth[a]) begin
        t = a;
        a = b;
        b = t;
      end
      // Lift the deeper node, but never above the depth of the other one.
      for (int k = LEVELS - 1; k >= 0; k--) begin
        ea = anc_rows[a][k];
        if (ea[NODE_W] && depth[ea[NODE_W-1:0]] >= depth[b]) a = ea[NODE_W-1:0];
      end
      if (a == b) begin
        lca = a;
      end else begin
        // Lift both together; a step is taken only when both ancestors
        // exist and differ.
        for (int k = LEVELS - 1; k >= 0; k--) begin
          ea = anc_rows[a][k];
          eb = anc_rows[b][k];
          if (ea != eb && ea[NODE_W] && eb[NODE_W]) begin
            a = ea[NODE_W-1:0];
            b = eb[NODE_W-1:0];
          end
        end
        ea = anc_rows[a][0];
        lca = ea[NODE_W-1:0];
        found = ea[NODE_W];
      end

      x.node_a = c.node;
      x.node_b = c.other_node;
      x.res.valid = 1'b1;
      if (found) begin
        x.res.common_ancestor = lca;
        x.res.distance = edges_up(depth[c.node], depth[lca])
                       + edges_up(depth[c.other_node], depth[lca]);
      end else begin
        // Nodes in different trees of the forest.
        x.res.common_ancestor = '0;
        x.res.distance = NO_PATH;
      end
      answers_q.insert(answers_q.size(), x);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      logic [NODE_W-1:0] got_anc;
      logic [DIST_W-1:0] got_dist;
      lca_expect_t       x;

      got_anc = d[NODE_W-1:0];
      got_dist = d[NODE_W +: DIST_W];
      if (answers_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: result with no query waiting: ancestor %0d distance %0d",
                   $time, got_anc, got_dist);
        return;
      end
      x = answers_q.pop_front();
      if (got_anc !== x.res.common_ancestor || got_dist !== x.res.distance) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: query (%0d, %0d): expected ancestor %0d distance %0d, got %0d %0d",
                   $time, x.node_a, x.node_b, x.res.common_ancestor, x.res.distance,
                   got_anc, got_dist);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  lca_scoreboard sb = new();

  // Nodes that have been loaded at least once; only these may be queried or
  // named as a parent, since the block's tables are undefined until written.
  bit                loaded [NODES];
  logic [NODE_W-1:0] loaded_ids[$];

  // Set while neither side may insert idle cycles.
  bit no_idle = 1'b0;

  tree_lca_binary_lifting #(
    .LEVELS(LEVELS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Every result transaction is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // The receiver stalls in random bursts, except while the no-idle flag is
  // up.
  initial begin
    @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Presents one transaction and holds it until the block takes it, then
  // hands it to the scoreboard. The sender may then idle for a short burst.
  task automatic send_cmd(input tlca_cmd_t c);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - 2 * NODE_W){1'b0}}, c.other_node, c.node};
    in_tuser <= {c.is_root, c.func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(c);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // A root load ignores the parent field, so it may carry any value.
  task automatic load_node(input logic [NODE_W-1:0] n, input logic [NODE_W-1:0] parent,
                           input bit root);
    tlca_cmd_t c;
    c.func = FUNC_LOAD;
    c.is_root = root;
    c.node = n;
    c.other_node = parent;
    send_cmd(c);
    if (!loaded[n]) begin
      loaded[n] = 1'b1;
      loaded_ids.insert(loaded_ids.size(), n);
    end
  endtask

  // The root flag means nothing on a query, so it is left random there.
  task automatic query_pair(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    tlca_cmd_t c;
    c.func = FUNC_QUERY;
    c.is_root = 1'($urandom_range(0, 1));
    c.node = a;
    c.other_node = b;
    send_cmd(c);
  endtask

  function automatic logic [NODE_W-1:0] any_loaded();
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  // Favoring recently loaded nodes as parents grows deep branches.
  function automatic logic [NODE_W-1:0] recent_loaded();
    int lo;
    lo = (loaded_ids.size() > 8) ? loaded_ids.size() - 8 : 0;
    return loaded_ids[$urandom_range(lo, loaded_ids.size() - 1)];
  endfunction

  initial begin
    int                sel;
    int                j;
    int                r;
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] chain [NODES];
    logic [NODE_W-1:0] swap;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a small tree over the extreme and alternating node
    // numbers, a second tree, then re-rooting and a node made its own parent.
    load_node(10'd0, 10'd1023, 1'b1);
    load_node(10'd1023, 10'd0, 1'b0);
    load_node(10'd512, 10'd1023, 1'b0);
    load_node(10'd341, 10'd512, 1'b0);
    load_node(10'd682, 10'd341, 1'b0);
    load_node(10'd5, 10'd0, 1'b1);
    load_node(10'd6, 10'd5, 1'b0);
    query_pair(10'd0, 10'd0);
    query_pair(10'd682, 10'd0);
    query_pair(10'd0, 10'd682);
    query_pair(10'd1023, 10'd1023);
    query_pair(10'd682, 10'd6);
    query_pair(10'd6, 10'd5);
    load_node(10'd100, 10'd0, 1'b0);
    query_pair(10'd100, 10'd682);
    query_pair(10'd341, 10'd1023);
    // Re-rooting 512 leaves the rows of 341 and 682 pointing past it, so the
    // lifting passes see ancestor rows that no longer agree with the depths.
    load_node(10'd512, 10'd0, 1'b1);
    query_pair(10'd682, 10'd1023);
    query_pair(10'd682, 10'd512);
    query_pair(10'd100, 10'd341);
    load_node(10'd6, 10'd6, 1'b0);
    query_pair(10'd6, 10'd5);
    query_pair(10'd6, 10'd6);

    // Random part: mostly growing a forest and querying it, with a few
    // re-loads of existing nodes mixed in as noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 200 && i < 260);
      sel = $urandom_range(0, 99);
      if (sel < 40 && loaded_ids.size() < NODES) begin
        n = NODE_W'($urandom_range(0, NODES - 1));
        while (loaded[n]) n = NODE_W'($urandom_range(0, NODES - 1));
        if ($urandom_range(0, 11) == 0)
          load_node(n, NODE_W'($urandom_range(0, NODES - 1)), 1'b1);
        else if ($urandom_range(0, 9) < 7)
          load_node(n, recent_loaded(), 1'b0);
        else
          load_node(n, any_loaded(), 1'b0);
      end else if (sel < 46) begin
        n = any_loaded();
        if ($urandom_range(0, 3) == 0)
          load_node(n, NODE_W'($urandom_range(0, NODES - 1)), 1'b1);
        else load_node(n, any_loaded(), 1'b0);
      end else begin
        n = any_loaded();
        if (sel < 54) b = n;
        else if (sel < 70) b = recent_loaded();
        else b = any_loaded();
        query_pair(n, b);
      end
    end

    // Hold the sender back until every pending query has been answered.
    no_idle = 1'b0;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // Last part, with no idling: one chain through randomly chosen nodes,
    // long enough to use the upper jump levels.
    no_idle = 1'b1;
    for (int i = 0; i < NODES; i++) chain[i] = NODE_W'(i);
    for (int i = NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = chain[i];
      chain[i] = chain[j];
      chain[j] = swap;
    end
    load_node(chain[0], NODE_W'($urandom_range(0, NODES - 1)), 1'b1);
    for (int i = 1; i < CHAIN_LEN; i++) load_node(chain[i], chain[i-1], 1'b0);
    query_pair(chain[0], chain[CHAIN_LEN-1]);
    query_pair(chain[CHAIN_LEN-1], chain[0]);
    for (int i = 0; i < 30; i++)
      query_pair(chain[$urandom_range(0, CHAIN_LEN - 1)],
                 chain[$urandom_range(0, CHAIN_LEN - 1)]);

    // Hang the leaf off random points of the chain to get true branch points.
    for (int i = 0; i < 5; i++) begin
      r = $urandom_range(0, CHAIN_LEN - 3);
      load_node(chain[CHAIN_LEN-1], chain[r], 1'b0);
      for (int q = 0; q < 4; q++)
        query_pair(chain[CHAIN_LEN-1], chain[$urandom_range(0, CHAIN_LEN - 2)]);
    end

    // Put the leaf back at the bottom, then give the root the leaf as its
    // parent, which closes the chain into a cycle.
    load_node(chain[CHAIN_LEN-1], chain[CHAIN_LEN-2], 1'b0);
    load_node(chain[0], chain[CHAIN_LEN-1], 1'b0);
    query_pair(chain[0], chain[CHAIN_LEN-1]);
    query_pair(chain[0], chain[0]);
    query_pair(chain[1], chain[0]);
    for (int i = 0; i < 15; i++)
      query_pair(chain[$urandom_range(0, CHAIN_LEN - 1)],
                 chain[$urandom_range(0, CHAIN_LEN - 1)]);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.n_errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
